[src/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store: sizes, command
// and status codes, and the memory request bundle.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int MODE_W   = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_INSERT     = 3'd2,
    MODE_REMOVE     = 3'd3,
    MODE_POP_FRONT  = 3'd4,
    MODE_POP_BACK   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[src/pls_mem.sv]
// ----------------------------------------------------------------------------
// pls_mem
// Element storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pls_mem (
  input  logic                             clk,
  input  pls_pkg::mem_req_t                req,
  output logic [pls_pkg::DATA_W-1:0]       rdata
);

  logic [pls_pkg::DATA_W-1:0] cells [pls_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
    rdata <= cells[req.raddr];
  end

endmodule

[src/pls_ctrl.sv]
// ----------------------------------------------------------------------------
// pls_ctrl
// Command sequencer: moves elements one at a time through the memory port to
// open or close a gap, then reads front and back and reports the result.
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pls_pkg::MODE_W-1:0]       mode,
  input  logic [pls_pkg::POS_W-1:0]        position,
  input  logic [pls_pkg::DATA_W-1:0]       value,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [pls_pkg::CNT_W-1:0]        count,
  output logic [pls_pkg::DATA_W-1:0]       front_value,
  output logic [pls_pkg::DATA_W-1:0]       back_value,
  output pls_pkg::mem_req_t                mem_req,
  input  logic [pls_pkg::DATA_W-1:0]       rdata
);

  typedef enum logic [8:0] {
    IDLE     = 9'b000000001,
    OPEN_RD  = 9'b000000010,
    OPEN_WR  = 9'b000000100,
    PLACE    = 9'b000001000,
    CLOSE_RD = 9'b000010000,
    CLOSE_WR = 9'b000100000,
    FRONT    = 9'b001000000,
    BACK     = 9'b010000000,
    REPORT   = 9'b100000000
  } state_t;

  state_t                          state;
  logic [pls_pkg::CNT_W-1:0]       fill;
  logic [pls_pkg::ADDR_W-1:0]      idx;
  logic [pls_pkg::ADDR_W-1:0]      at;
  logic [pls_pkg::DATA_W-1:0]      val;
  pls_pkg::status_t                stat;
  logic [pls_pkg::DATA_W-1:0]      front_q;

  logic                            full;
  logic                            empty;
  logic [pls_pkg::CMP_W-1:0]       pos_ext;
  logic [pls_pkg::CMP_W-1:0]       fill_ext;
  logic                            pos_in;
  logic [pls_pkg::ADDR_W-1:0]      ins_at;
  logic [pls_pkg::ADDR_W-1:0]      idx_dec;
  logic [pls_pkg::ADDR_W-1:0]      idx_inc;
  logic [pls_pkg::ADDR_W-1:0]      last_addr;
  logic                            accept;

  assign busy     = (state != IDLE);
  assign accept   = start && (state == IDLE);
  assign full     = (fill == pls_pkg::CNT_W'(pls_pkg::CAPACITY));
  assign empty    = (fill == '0);
  assign pos_ext  = pls_pkg::CMP_W'(position);
  assign fill_ext = pls_pkg::CMP_W'(fill);
  assign pos_in   = (pos_ext < fill_ext);
  assign idx_dec  = idx - 1'b1;
  assign idx_inc  = idx + 1'b1;
  assign last_addr = pls_pkg::ADDR_W'(fill - 1'b1);

  // landing index of a push or insert; fill is below capacity here
  always_comb begin
    if (mode == pls_pkg::MODE_PUSH_FRONT) begin
      ins_at = '0;
    end else if (mode == pls_pkg::MODE_PUSH_BACK || !pos_in) begin
      ins_at = pls_pkg::ADDR_W'(fill);
    end else begin
      ins_at = pls_pkg::ADDR_W'(position);
    end
  end

  always_comb begin
    mem_req       = '0;
    mem_req.waddr = idx;
    mem_req.wdata = rdata;
    mem_req.raddr = idx;
    unique case (state)
      OPEN_RD:  mem_req.raddr = idx_dec;
      OPEN_WR:  mem_req.we    = 1'b1;
      PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = at;
        mem_req.wdata = val;
      end
      CLOSE_RD: mem_req.raddr = idx_inc;
      CLOSE_WR: mem_req.we    = 1'b1;
      FRONT:    mem_req.raddr = '0;
      BACK:     mem_req.raddr = last_addr;
      default:  mem_req.raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            stat  <= pls_pkg::ST_OK;
            val   <= value;
            state <= FRONT;
            unique case (mode)
              pls_pkg::MODE_PUSH_FRONT, pls_pkg::MODE_PUSH_BACK,
              pls_pkg::MODE_INSERT: begin
                if (full) begin
                  stat <= pls_pkg::ST_FULL;
                end else begin
                  at    <= ins_at;
                  idx   <= pls_pkg::ADDR_W'(fill);
                  fill  <= fill + 1'b1;
                  state <= (pls_pkg::ADDR_W'(fill) > ins_at) ? OPEN_RD : PLACE;
                end
              end
              pls_pkg::MODE_REMOVE: begin
                if (empty) begin
                  stat <= pls_pkg::ST_EMPTY;
                end else if (!pos_in) begin
                  stat <= pls_pkg::ST_ABSENT;
                end else begin
                  idx  <= pls_pkg::ADDR_W'(position);
                  fill <= fill - 1'b1;
                  if ((pos_ext + 1'b1) < fill_ext) begin
                    state <= CLOSE_RD;
                  end
                end
              end
              pls_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                  stat <= pls_pkg::ST_EMPTY;
                end else begin
                  idx  <= '0;
                  fill <= fill - 1'b1;
                  if (fill > pls_pkg::CNT_W'(1)) begin
                    state <= CLOSE_RD;
                  end
                end
              end
              pls_pkg::MODE_POP_BACK: begin
                if (empty) begin
                  stat <= pls_pkg::ST_EMPTY;
                end else begin
                  fill <= fill - 1'b1;
                end
              end
              default: begin
                stat <= pls_pkg::ST_OK;
              end
            endcase
          end
        end
        OPEN_RD: begin
          state <= OPEN_WR;
        end
        OPEN_WR: begin
          idx   <= idx_dec;
          state <= (idx_dec > at) ? OPEN_RD : PLACE;
        end
        PLACE: begin
          state <= FRONT;
        end
        CLOSE_RD: begin
          state <= CLOSE_WR;
        end
        CLOSE_WR: begin
          idx <= idx_inc;
          // fill is already the post-removal count
          state <= ((pls_pkg::CNT_W'(idx) + pls_pkg::CNT_W'(1)) < fill) ? CLOSE_RD : FRONT;
        end
        FRONT: begin
          state <= BACK;
        end
        BACK: begin
          front_q <= rdata;
          state   <= REPORT;
        end
        REPORT: begin
          done        <= 1'b1;
          status      <= stat;
          count       <= fill;
          front_value <= empty ? '0 : front_q;
          back_value  <= empty ? '0 : rdata;
          state       <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
    else $error("element count above capacity");

  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == REPORT))
    else $error("result strobe without report step");

  a_fill_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> fill == $past(fill))
    else $error("element count changed outside a command transfer");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("command transfer did not start a sequence");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && state != PLACE) |-> (pls_pkg::CNT_W'(mem_req.waddr) < fill))
    else $error("element move beyond the list end");
`endif

endmodule

[src/positional_list_store_core.sv]
// ----------------------------------------------------------------------------
// positional_list_store_core
// Bounded ordered list of signed 32-bit values with push, insert, remove and
// pop commands; each command returns status, count, front and back.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result appears
// on status, count, front_value and back_value for exactly one cycle with
// done high; the receiver cannot stall, so it must capture the result then.
// The elements sit in a single-port-write memory and every element that has
// to move goes through it one at a time, as a read and then a write. busy
// falls in the cycle done is shown, so the next command can be taken in
// that same cycle.
// ----------------------------------------------------------------------------
module positional_list_store_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [pls_pkg::MODE_W-1:0]         mode,
  input  logic [pls_pkg::POS_W-1:0]          position,
  input  logic signed [pls_pkg::DATA_W-1:0]  value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [pls_pkg::CNT_W-1:0]          count,
  output logic signed [pls_pkg::DATA_W-1:0]  front_value,
  output logic signed [pls_pkg::DATA_W-1:0]  back_value
);

  pls_pkg::mem_req_t          mem_req;
  logic [pls_pkg::DATA_W-1:0] rdata;
  logic [pls_pkg::DATA_W-1:0] front_raw;
  logic [pls_pkg::DATA_W-1:0] back_raw;

  pls_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .done        (done),
    .status      (status),
    .count       (count),
    .front_value (front_raw),
    .back_value  (back_raw),
    .mem_req     (mem_req),
    .rdata       (rdata)
  );

  pls_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign front_value = $signed(front_raw);
  assign back_value  = $signed(back_raw);

endmodule
